// File: rtl/vdg_pkg.sv
// Package for the vertex duplicate grouper.
// Holds the store size, derived widths and the packed vertex type.
// No dependencies.
package vdg_pkg;

  // Number of vertex entries in the store.
  localparam int unsigned MAX_VERTICES = 64;
  // Width of an entry index and of a count that can hold MAX_VERTICES.
  localparam int unsigned IDX_W = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);

  // Coordinate and packed vertex widths.
  localparam int unsigned COORD_W = 16;
  localparam int unsigned VERT_W  = 3 * COORD_W;

  // Output field widths.
  localparam int unsigned VIDX_W  = 6;
  localparam int unsigned GROUP_W = 6;

  // One stored vertex, packed as z:y:x, with x in the low bits.
  typedef logic [VERT_W-1:0] vertex_t;

endpackage : vdg_pkg

// File: rtl/vertex_duplicate_grouper_top.sv
// Top level of the vertex duplicate grouper.
// Depends on vdg_pkg for sizes and the packed vertex type.
//
// The block loads one vertex per request (x, y, z as signed 16-bit values)
// into a 64-entry store. The request with tlast set is stored and then starts
// grouping: vertices with identical coordinates form a group, groups come out
// in order of their lowest index, and each group lists its members in
// ascending order, with tlast on the last member of a group and tuser on the
// very last result of the model. Grouping uses one memory read port and one
// 48-bit comparator: for each group leader it reads the leader, then reads and
// compares every later index; already grouped indices are skipped as leaders
// and never match. A result that waits for a full output register to drain
// stalls the scan. The store is cleared for the next model after the last
// result has been handed to the output register. No request is taken while
// grouping runs; a full store drops further vertices.
module vertex_duplicate_grouper_top
  import vdg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // coord_x [15:0], coord_y [31:16], coord_z [47:32]
  input  logic        s_axis_tlast_i,  // final_vertex
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // vertex_index [5:0], group_number [11:6], zeros
  output logic        m_axis_tlast_o,  // end_of_group
  output logic        m_axis_tuser_o   // end_of_model
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIND = 2'd1;
  localparam logic [1:0] S_REF  = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        lead_q, lead_d;
  logic [CNT_W-1:0]        scan_q, scan_d;
  logic [GROUP_W-1:0]      group_q, group_d;
  logic [MAX_VERTICES-1:0] grouped_q, grouped_d;
  logic                    rd_valid_q, rd_valid_d;
  logic [IDX_W-1:0]        rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]        pend_q, pend_d;
  vertex_t                 ref_q, ref_d;

  logic                    out_valid_q, out_valid_d;
  logic [VIDX_W-1:0]       out_idx_q, out_idx_d;
  logic [GROUP_W-1:0]      out_group_q, out_group_d;
  logic                    out_eog_q, out_eog_d;
  logic                    out_eom_q, out_eom_d;

  // Vertex store and its registered read port.
  vertex_t                 store_mem [MAX_VERTICES];
  vertex_t                 rdata_q;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;

  logic                    in_acc;
  logic                    can_emit;
  logic                    match;
  logic                    all_grouped;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign can_emit = !out_valid_q || m_axis_tready_i;
  assign match    = rd_valid_q && (rdata_q == ref_q) && !grouped_q[rd_idx_q];

  // Every loaded index has been placed in a group.
  always_comb begin
    all_grouped = 1'b1;
    for (int k = 0; k < MAX_VERTICES; k++) begin
      if ((CNT_W'(k) < count_q) && !grouped_q[k]) begin
        all_grouped = 1'b0;
      end
    end
  end

  // Memory write and read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= vertex_t'(s_axis_tdata_i);
    end
    if (rd_en) begin
      rdata_q <= store_mem[rd_addr];
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lead_d      = lead_q;
    scan_d      = scan_q;
    group_d     = group_q;
    grouped_d   = grouped_q;
    rd_valid_d  = rd_valid_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = pend_q;
    ref_d       = ref_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_idx_d   = out_idx_q;
    out_group_d = out_group_q;
    out_eog_d   = out_eog_q;
    out_eom_d   = out_eom_q;
    wr_en       = 1'b0;
    wr_addr     = count_q[IDX_W-1:0];
    rd_en       = 1'b0;
    rd_addr     = lead_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (count_q < CNT_W'(MAX_VERTICES)) begin
            wr_en   = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
          if (s_axis_tlast_i) begin
            lead_d  = '0;
            group_d = '0;
            state_d = S_FIND;
          end
        end
      end

      // Walk to the next index that is not yet in a group.
      S_FIND: begin
        if (lead_q == count_q) begin
          count_d   = '0;
          grouped_d = '0;
          state_d   = S_IDLE;
        end else if (grouped_q[lead_q[IDX_W-1:0]]) begin
          lead_d = lead_q + CNT_W'(1);
        end else begin
          rd_en   = 1'b1;
          state_d = S_REF;
        end
      end

      // Leader data arrives: it opens the group as the pending member.
      S_REF: begin
        ref_d      = rdata_q;
        pend_d     = lead_q[IDX_W-1:0];
        grouped_d[lead_q[IDX_W-1:0]] = 1'b1;
        scan_d     = lead_q + CNT_W'(1);
        rd_valid_d = 1'b0;
        state_d    = S_SCAN;
      end

      // Read one entry per cycle, unless a match waits for the output register, and compare the previous one.
      S_SCAN: begin
        if (!rd_valid_q && (scan_q >= count_q)) begin
          // Scan done: the pending member closes the group.
          if (can_emit) begin
            out_valid_d = 1'b1;
            out_idx_d   = VIDX_W'(pend_q);
            out_group_d = group_q;
            out_eog_d   = 1'b1;
            out_eom_d   = all_grouped;
            group_d     = group_q + GROUP_W'(1);
            lead_d      = lead_q + CNT_W'(1);
            state_d     = S_FIND;
          end
        end else if (!(match && !can_emit)) begin
          if (match) begin
            out_valid_d = 1'b1;
            out_idx_d   = VIDX_W'(pend_q);
            out_group_d = group_q;
            out_eog_d   = 1'b0;
            out_eom_d   = 1'b0;
            pend_d      = rd_idx_q;
            grouped_d[rd_idx_q] = 1'b1;
          end
          if (scan_q < count_q) begin
            rd_en      = 1'b1;
            rd_addr    = scan_q[IDX_W-1:0];
            rd_valid_d = 1'b1;
            rd_idx_d   = scan_q[IDX_W-1:0];
            scan_d     = scan_q + CNT_W'(1);
          end else begin
            rd_valid_d = 1'b0;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      grouped_q   <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lead_q      <= '0;
      scan_q      <= '0;
      group_q     <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      grouped_q   <= grouped_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
      lead_q      <= lead_d;
      scan_q      <= scan_d;
      group_q     <= group_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    pend_q      <= pend_d;
    ref_q       <= ref_d;
    out_idx_q   <= out_idx_d;
    out_group_q <= out_group_d;
    out_eog_q   <= out_eog_d;
    out_eom_q   <= out_eom_d;
  end

  // Port drive.
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_group_q, out_idx_q};
  assign m_axis_tlast_o  = out_eog_q;
  assign m_axis_tuser_o  = out_eom_q;

endmodule : vertex_duplicate_grouper_top
